[rtl/assert_macros.svh]
// Assertion macros shared by the heap sort RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define HS_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define HS_ASSERT(name, clk, rst, prop)
`define HS_NEVER(name, clk, rst, expr)
`endif
`endif

[rtl/hsort_pkg.sv]
// Package for the heap sort unit: sizes, the stored pair type and sequencer states.
// No dependencies.
package hsort_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [VALUE_W-1:0]      value;
   } pair_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OUTER,
      ST_LOAD_HOLD,
      ST_EXTRACT0,
      ST_EXTRACT1,
      ST_SIFT,
      ST_CHILD0,
      ST_CHILD1,
      ST_FINAL,
      ST_EMIT
   } state_type;

endpackage

[rtl/heap_sort_key_value_pairs_unit.sv]
// Load time: one item per cycle while idle. Sort of n pairs: n/2 heap build passes plus
// n-1 extractions; each sift-down level steps ST_SIFT, ST_CHILD0, ST_CHILD1 on one read
// and one write memory port, each extraction adds ST_OUTER, ST_EXTRACT0, ST_EXTRACT1.
// n results follow, which cannot be stalled; busy is high from end-of-set item to last result.
// Sync reset clears fill count, ovf flag, sequencer, valid/final flags; pair memory is kept.
// Depends on hsort_pkg and assert_macros.svh.
module heap_sort_key_value_pairs_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [hsort_pkg::KEY_W-1:0]   req_sort_key,
   input  logic [hsort_pkg::VALUE_W-1:0]        req_payload,
   input  logic                                 req_end_of_set,
   output logic                                 rsp_valid,
   output logic signed [hsort_pkg::KEY_W-1:0]   rsp_sorted_key,
   output logic [hsort_pkg::VALUE_W-1:0]        rsp_sorted_payload,
   output logic                                 rsp_final_pair,
   output logic                                 rsp_overflowed
);
   import hsort_pkg::*;
`include "assert_macros.svh"

   pair_type pair_mem [DEPTH];
   pair_type rdata_ff;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic                 ovf_ff, ovf_in;
   logic [CNT_W-1:0]     l_ff, l_in;
   logic [CNT_W-1:0]     ir_ff, ir_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W:0]       j_ff, j_in;
   pair_type             hold_ff, hold_in;
   pair_type             child_ff, child_in;
   logic [ADDR_W-1:0]    emit_ff, emit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_final_ff, rsp_final_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   pair_type             wr_data;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;

   logic [CNT_W-1:0]     fill_sum;
   logic [CNT_W-1:0]     l_m2, ir_m1, i_m1;
   logic [CNT_W:0]       j_m1, j_best;
   logic                 right_ok;
   pair_type             best;
   logic                 last_emit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pair_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= pair_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_final_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_final_ff <= rsp_final_in;
      end
      l_ff       <= l_in;
      ir_ff      <= ir_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      hold_ff    <= hold_in;
      child_ff   <= child_in;
      emit_ff    <= emit_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      l_in         = l_ff;
      ir_in        = ir_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      hold_in      = hold_ff;
      child_in     = child_ff;
      emit_in      = emit_ff;
      rsp_valid_in = 1'b0;
      rsp_final_in = 1'b0;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = hold_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      fill_sum  = fill_ff;
      l_m2      = l_ff - CNT_W'(2);
      ir_m1     = ir_ff - 1'b1;
      i_m1      = i_ff - 1'b1;
      j_m1      = j_ff - 1'b1;
      right_ok  = (j_ff < {1'b0, ir_ff});
      last_emit = ({1'b0, emit_ff} == (fill_ff - 1'b1));
      // pick the larger child, the right one only when strictly greater
      if (right_ok && (child_ff.key < rdata_ff.key)) begin
         best   = rdata_ff;
         j_best = j_ff + 1'b1;
      end else begin
         best   = child_ff;
         j_best = j_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (fill_ff < CNT_W'(DEPTH)) begin
                  wr_en    = 1'b1;
                  wr_addr  = fill_ff[ADDR_W-1:0];
                  wr_data  = '{key: req_sort_key, value: req_payload};
                  fill_sum = fill_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               fill_in = fill_sum;
               if (req_end_of_set) begin
                  ir_in   = fill_sum;
                  l_in    = (fill_sum >> 1) + 1'b1;
                  emit_in = '0;
                  if (fill_sum >= CNT_W'(2)) begin
                     state_in = ST_OUTER;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_OUTER: begin
            rd_en = 1'b1;
            if (l_ff > CNT_W'(1)) begin
               // heap build: sift the next internal node
               l_in     = l_ff - 1'b1;
               rd_addr  = l_m2[ADDR_W-1:0];
               state_in = ST_LOAD_HOLD;
            end else begin
               rd_addr  = ir_m1[ADDR_W-1:0];
               state_in = ST_EXTRACT0;
            end
         end
         ST_LOAD_HOLD: begin
            hold_in  = rdata_ff;
            i_in     = l_ff;
            j_in     = {l_ff, 1'b0};
            state_in = ST_SIFT;
         end
         ST_EXTRACT0: begin
            hold_in  = rdata_ff;
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = ST_EXTRACT1;
         end
         ST_EXTRACT1: begin
            // move the heap top to the end of the shrinking heap
            wr_en   = 1'b1;
            wr_addr = ir_m1[ADDR_W-1:0];
            wr_data = rdata_ff;
            ir_in   = ir_m1;
            if (ir_m1 == CNT_W'(1)) begin
               state_in = ST_FINAL;
            end else begin
               i_in     = l_ff;
               j_in     = {l_ff, 1'b0};
               state_in = ST_SIFT;
            end
         end
         ST_SIFT: begin
            if (j_ff <= {1'b0, ir_ff}) begin
               rd_en    = 1'b1;
               rd_addr  = j_m1[ADDR_W-1:0];
               state_in = ST_CHILD0;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = i_m1[ADDR_W-1:0];
               wr_data  = hold_ff;
               state_in = ST_OUTER;
            end
         end
         ST_CHILD0: begin
            child_in = rdata_ff;
            if (right_ok) begin
               rd_en   = 1'b1;
               rd_addr = j_ff[ADDR_W-1:0];
            end
            state_in = ST_CHILD1;
         end
         ST_CHILD1: begin
            wr_en   = 1'b1;
            wr_addr = i_m1[ADDR_W-1:0];
            if (hold_ff.key < best.key) begin
               wr_data  = best;
               i_in     = j_best[CNT_W-1:0];
               j_in     = {j_best[CNT_W-1:0], 1'b0};
               state_in = ST_SIFT;
            end else begin
               wr_data  = hold_ff;
               state_in = ST_OUTER;
            end
         end
         ST_FINAL: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = hold_ff;
            emit_in  = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rd_en        = 1'b1;
            rd_addr      = emit_ff;
            emit_in      = emit_ff + 1'b1;
            rsp_valid_in = 1'b1;
            rsp_final_in = last_emit;
            rsp_ovf_in   = ovf_ff;
            if (last_emit) begin
               fill_in  = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sorted_key     = rdata_ff.key;
   assign rsp_sorted_payload = rdata_ff.value;
   assign rsp_final_pair     = rsp_final_ff;
   assign rsp_overflowed     = rsp_ovf_ff;

   `HS_NEVER(a_fill_bound, clock, reset, fill_ff > CNT_W'(DEPTH))
   `HS_ASSERT(a_ovf_full, clock, reset, ovf_ff |-> (fill_ff == CNT_W'(DEPTH)))
   `HS_ASSERT(a_final_valid, clock, reset, rsp_final_pair |-> rsp_valid)
   `HS_ASSERT(a_end_busy, clock, reset, (start && !busy && req_end_of_set) |=> busy)
   `HS_ASSERT(a_sift_node, clock, reset,
      (state_ff == ST_SIFT) |-> ((i_ff <= ir_ff) && (i_ff != '0)))

endmodule
